### rtl/core/greedy_text_wrap_layout_macros.svh
// Assertion helpers for the checker of this block.
`ifndef GREEDY_TEXT_WRAP_LAYOUT_MACROS_SVH
`define GREEDY_TEXT_WRAP_LAYOUT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define GTW_ASSERT_RST(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Same, on the clk / rst_n pair of the enclosing module.
`define GTW_ASSERT(lbl, prop, msg) `GTW_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`endif

### rtl/core/gtw_pkg.sv
`default_nettype none

package gtw_pkg;

  localparam int unsigned MAX_WORD_DEF      = 16;
  localparam int unsigned MAX_PLACED_DEF    = 8192;
  localparam int unsigned GLYPH_ENTRIES_DEF = 95;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [23:0] MAX_WIDTH_RST = 24'd491520;
  localparam logic [23:0] SAT24         = 24'hFFFFFF;
  localparam logic [15:0] LINE_MAX      = 16'hFFFF;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TEXT = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_LINE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_APPEND_ADD,
    ST_FLUSH,
    ST_FLUSH_NL,
    ST_RD_BUF,
    ST_RD_TAB,
    ST_BREAK,
    ST_PUT,
    ST_POST,
    ST_NEWLINE,
    ST_END,
    ST_SP_RD,
    ST_SP_ADD
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [6:0]  glyph_id;
    logic [23:0] position;
    logic [15:0] line_number;
    logic        last;
  } rec_t;

  function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? SAT24 : s[23:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/gtw_if.sv
`default_nettype none

interface gtw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  glyph_slot;
  logic [15:0] glyph_advance;
  logic        glyph_has_bitmap;
  logic [7:0]  char_code;

  modport source (output valid, cmd, glyph_slot, glyph_advance, glyph_has_bitmap, char_code,
                  input ready);
  modport sink (input valid, cmd, glyph_slot, glyph_advance, glyph_has_bitmap, char_code,
                output ready);
endinterface

interface gtw_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  glyph_id;
  logic [23:0] position;
  logic [15:0] line_number;
  logic        last;

  modport source (output valid, kind, glyph_id, position, line_number, last, input ready);
  modport sink (input valid, kind, glyph_id, position, line_number, last, output ready);
endinterface

interface gtw_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] max_width;

  modport source (output valid, max_width, input ready);
  modport sink (input valid, max_width, output ready);
endinterface

`default_nettype wire

### rtl/core/greedy_text_wrap_layout.sv
// A table load or ignored command is taken when idle; a word character is stored in the
// word buffer and its glyph advance added to the word width. A break character, end of
// text or a character at a full buffer first flushes the word, reading each character
// from the word buffer, then the glyph table. Input is taken only when idle; output
// stalls hold the flow only while a record waits. Reset (rst_n low, synchronous) clears
// pen, line, word and placed counters, restores max_width; the glyph table is kept.
`default_nettype none

module greedy_text_wrap_layout #(
  parameter int MAX_WORD      = gtw_pkg::MAX_WORD_DEF,
  parameter int MAX_PLACED    = gtw_pkg::MAX_PLACED_DEF,
  parameter int GLYPH_ENTRIES = gtw_pkg::GLYPH_ENTRIES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gtw_in_if.sink    in_ch,
  gtw_out_if.source out_ch,
  gtw_cfg_if.sink   cfg_ch
);

  localparam int LEN_W  = $clog2(MAX_WORD + 1);
  localparam int BUF_AW = $clog2(MAX_WORD);
  localparam int TAB_AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int PL_W   = $clog2(MAX_PLACED + 1);

  gtw_pkg::state_t state_r, state_nxt;

  logic [1:0]       cmd_r, cmd_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [LEN_W-1:0] word_len_r, word_len_nxt;
  logic [23:0]      word_width_r, word_width_nxt;
  logic [23:0]      pen_r, pen_nxt;
  logic [15:0]      line_r, line_nxt;
  logic [PL_W-1:0]  placed_r, placed_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             brk_r, brk_nxt;
  logic             code_ok_r, code_ok_nxt;
  logic [6:0]       code_id_r, code_id_nxt;
  logic [23:0]      max_width_r;

  // memory ports
  logic              tab_we, tab_re;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic [16:0]       tab_wdata, tab_rdata;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]        buf_wdata, buf_rdata;

  logic          emit;
  gtw_pkg::rec_t rec;
  logic          out_free;

  function automatic logic has_glyph(input logic [7:0] c);
    logic [7:0] off;
    off = c - gtw_pkg::FIRST_CODE;
    return (c >= gtw_pkg::FIRST_CODE) && (c <= gtw_pkg::LAST_CODE) &&
           (off < 8'(GLYPH_ENTRIES));
  endfunction

  logic [7:0]  chr_off, buf_off;
  logic        chr_ok, buf_ok;
  logic        is_nl, is_tab, is_sp;
  logic        in_is_break;
  logic        in_acc;
  logic [15:0] tab_adv;
  logic        tab_bm;
  logic [23:0] glyph_adv;
  logic [24:0] pen_adv_sum, pen_ww_sum;
  logic        pen_nz;
  logic        ww_over;
  logic        nb_nl, brk_nl, need_glyph, flush_last;
  logic [15:0] line_inc;

  assign chr_off = char_r - gtw_pkg::FIRST_CODE;
  assign buf_off = buf_rdata - gtw_pkg::FIRST_CODE;
  assign chr_ok  = has_glyph(char_r);
  assign buf_ok  = has_glyph(buf_rdata);

  assign is_nl  = (char_r == gtw_pkg::CHAR_NL);
  assign is_tab = (char_r == gtw_pkg::CHAR_TAB);
  assign is_sp  = is_tab || (char_r == gtw_pkg::CHAR_SPACE);

  assign in_is_break = (in_ch.char_code == gtw_pkg::CHAR_NL) ||
                       (in_ch.char_code == gtw_pkg::CHAR_SPACE) ||
                       (in_ch.char_code == gtw_pkg::CHAR_TAB);

  assign in_ch.ready = (state_r == gtw_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign tab_adv   = tab_rdata[15:0];
  assign tab_bm    = tab_rdata[16];
  assign glyph_adv = code_ok_r ? {8'd0, tab_adv} : 24'd0;

  assign pen_adv_sum = {1'b0, pen_r} + {1'b0, glyph_adv};
  assign pen_ww_sum  = {1'b0, pen_r} + {1'b0, word_width_r};
  assign pen_nz      = (pen_r != 24'd0);
  assign ww_over     = (word_width_r > max_width_r);

  // whole word moves to a new line
  assign nb_nl      = !ww_over && pen_nz && (pen_ww_sum > {1'b0, max_width_r});
  // over-wide word, broken before this character
  assign brk_nl     = pen_nz && (pen_adv_sum > {1'b0, max_width_r});
  assign need_glyph = code_ok_r && tab_bm && (placed_r < PL_W'(MAX_PLACED));
  assign flush_last = ((idx_r + LEN_W'(1)) == word_len_r);
  assign line_inc   = (line_r == gtw_pkg::LINE_MAX) ? line_r : line_r + 16'd1;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r <= gtw_pkg::MAX_WIDTH_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_width_r <= cfg_ch.max_width;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtw_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.cmd)
            gtw_pkg::CMD_TEXT: begin
              if (in_is_break || (word_len_r >= LEN_W'(MAX_WORD))) begin
                state_nxt = gtw_pkg::ST_FLUSH;
              end else begin
                state_nxt = gtw_pkg::ST_APPEND;
              end
            end
            gtw_pkg::CMD_END: state_nxt = gtw_pkg::ST_FLUSH;
            default:          state_nxt = gtw_pkg::ST_IDLE;
          endcase
        end
      end
      gtw_pkg::ST_APPEND:     state_nxt = gtw_pkg::ST_APPEND_ADD;
      gtw_pkg::ST_APPEND_ADD: state_nxt = gtw_pkg::ST_IDLE;
      gtw_pkg::ST_FLUSH: begin
        if (word_len_r == '0) begin
          state_nxt = gtw_pkg::ST_POST;
        end else if (nb_nl) begin
          state_nxt = gtw_pkg::ST_FLUSH_NL;
        end else begin
          state_nxt = gtw_pkg::ST_RD_BUF;
        end
      end
      gtw_pkg::ST_FLUSH_NL: begin
        if (out_free) begin
          state_nxt = gtw_pkg::ST_RD_BUF;
        end
      end
      gtw_pkg::ST_RD_BUF: state_nxt = gtw_pkg::ST_RD_TAB;
      gtw_pkg::ST_RD_TAB: state_nxt = brk_r ? gtw_pkg::ST_BREAK : gtw_pkg::ST_PUT;
      gtw_pkg::ST_BREAK: begin
        if (!brk_nl || out_free) begin
          state_nxt = gtw_pkg::ST_PUT;
        end
      end
      gtw_pkg::ST_PUT: begin
        if (!need_glyph || out_free) begin
          state_nxt = flush_last ? gtw_pkg::ST_POST : gtw_pkg::ST_RD_BUF;
        end
      end
      gtw_pkg::ST_POST: begin
        if (cmd_r == gtw_pkg::CMD_END) begin
          state_nxt = gtw_pkg::ST_END;
        end else if (is_nl) begin
          state_nxt = gtw_pkg::ST_NEWLINE;
        end else if (is_sp) begin
          state_nxt = gtw_pkg::ST_SP_RD;
        end else begin
          state_nxt = gtw_pkg::ST_APPEND;
        end
      end
      gtw_pkg::ST_NEWLINE: begin
        if (out_free) begin
          state_nxt = gtw_pkg::ST_IDLE;
        end
      end
      gtw_pkg::ST_END: begin
        if (out_free) begin
          state_nxt = gtw_pkg::ST_IDLE;
        end
      end
      gtw_pkg::ST_SP_RD:  state_nxt = gtw_pkg::ST_SP_ADD;
      gtw_pkg::ST_SP_ADD: state_nxt = gtw_pkg::ST_IDLE;
      default:            state_nxt = gtw_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt        = cmd_r;
    char_nxt       = char_r;
    word_len_nxt   = word_len_r;
    word_width_nxt = word_width_r;
    pen_nxt        = pen_r;
    line_nxt       = line_r;
    placed_nxt     = placed_r;
    idx_nxt        = idx_r;
    brk_nxt        = brk_r;
    code_ok_nxt    = code_ok_r;
    code_id_nxt    = code_id_r;
    tab_we         = 1'b0;
    tab_waddr      = in_ch.glyph_slot[TAB_AW-1:0];
    tab_wdata      = {in_ch.glyph_has_bitmap, in_ch.glyph_advance};
    tab_re         = 1'b0;
    tab_raddr      = '0;
    buf_we         = 1'b0;
    buf_waddr      = word_len_r[BUF_AW-1:0];
    buf_wdata      = char_r;
    buf_re         = 1'b0;
    buf_raddr      = idx_r[BUF_AW-1:0];
    emit           = 1'b0;
    rec            = '0;
    rec.kind       = gtw_pkg::KIND_LINE;
    rec.position   = pen_r;
    rec.line_number = line_r;
    case (state_r)
      gtw_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_ch.cmd;
          char_nxt = in_ch.char_code;
          if ((in_ch.cmd == gtw_pkg::CMD_LOAD) &&
              ({1'b0, in_ch.glyph_slot} < 8'(GLYPH_ENTRIES))) begin
            tab_we = 1'b1;
          end
        end
      end
      gtw_pkg::ST_APPEND: begin
        buf_we    = 1'b1;
        tab_re    = 1'b1;
        tab_raddr = chr_off[TAB_AW-1:0];
      end
      gtw_pkg::ST_APPEND_ADD: begin
        word_width_nxt = gtw_pkg::sat_add24(word_width_r, chr_ok ? {8'd0, tab_adv} : 24'd0);
        word_len_nxt   = word_len_r + LEN_W'(1);
      end
      gtw_pkg::ST_FLUSH: begin
        brk_nxt = ww_over;
        idx_nxt = '0;
      end
      gtw_pkg::ST_FLUSH_NL: begin
        if (out_free) begin
          emit     = 1'b1;
          line_nxt = line_inc;
          pen_nxt  = 24'd0;
        end
      end
      gtw_pkg::ST_RD_BUF: begin
        buf_re = 1'b1;
      end
      gtw_pkg::ST_RD_TAB: begin
        code_ok_nxt = buf_ok;
        code_id_nxt = buf_off[6:0];
        tab_re      = 1'b1;
        tab_raddr   = buf_off[TAB_AW-1:0];
      end
      gtw_pkg::ST_BREAK: begin
        if (brk_nl && out_free) begin
          emit     = 1'b1;
          line_nxt = line_inc;
          pen_nxt  = 24'd0;
        end
      end
      gtw_pkg::ST_PUT: begin
        rec.kind     = gtw_pkg::KIND_GLYPH;
        rec.glyph_id = code_id_r;
        if (!need_glyph || out_free) begin
          if (need_glyph) begin
            emit       = 1'b1;
            placed_nxt = placed_r + PL_W'(1);
          end
          pen_nxt = gtw_pkg::sat_add24(pen_r, glyph_adv);
          idx_nxt = idx_r + LEN_W'(1);
          if (flush_last) begin
            word_len_nxt   = '0;
            word_width_nxt = 24'd0;
          end
        end
      end
      gtw_pkg::ST_NEWLINE: begin
        if (out_free) begin
          emit     = 1'b1;
          line_nxt = line_inc;
          pen_nxt  = 24'd0;
        end
      end
      gtw_pkg::ST_END: begin
        rec.last = 1'b1;
        if (out_free) begin
          emit       = 1'b1;
          pen_nxt    = 24'd0;
          line_nxt   = 16'd0;
          placed_nxt = '0;
        end
      end
      gtw_pkg::ST_SP_RD: begin
        tab_re = 1'b1;
      end
      gtw_pkg::ST_SP_ADD: begin
        if (pen_nz) begin
          pen_nxt = gtw_pkg::sat_add24(pen_r,
                                       is_tab ? {6'd0, tab_adv, 2'b00} : {8'd0, tab_adv});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gtw_pkg::ST_IDLE;
      word_len_r   <= '0;
      word_width_r <= 24'd0;
      pen_r        <= 24'd0;
      line_r       <= 16'd0;
      placed_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      word_len_r   <= word_len_nxt;
      word_width_r <= word_width_nxt;
      pen_r        <= pen_nxt;
      line_r       <= line_nxt;
      placed_r     <= placed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    char_r    <= char_nxt;
    idx_r     <= idx_nxt;
    brk_r     <= brk_nxt;
    code_ok_r <= code_ok_nxt;
    code_id_r <= code_id_nxt;
  end

  // {has_bitmap, advance} per glyph
  gtw_ram #(
    .WIDTH (17),
    .DEPTH (GLYPH_ENTRIES)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  gtw_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD)
  ) u_word_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  gtw_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .emit   (emit),
    .rec    (rec),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### rtl/core/gtw_ram.sv
`default_nettype none

module gtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/gtw_out_reg.sv
`default_nettype none

module gtw_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          emit,
  input  wire gtw_pkg::rec_t rec,
  output logic               free,
  gtw_out_if.source          out_ch
);

  logic          valid_r;
  logic          valid_nxt;
  gtw_pkg::rec_t rec_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rec_r <= rec;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.kind        = rec_r.kind;
  assign out_ch.glyph_id    = rec_r.glyph_id;
  assign out_ch.position    = rec_r.position;
  assign out_ch.line_number = rec_r.line_number;
  assign out_ch.last        = rec_r.last;

endmodule

`default_nettype wire

### rtl/core/gtw_checker.sv
`default_nettype none
`include "greedy_text_wrap_layout_macros.svh"

module gtw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [6:0]  out_glyph_id,
  input wire logic [23:0] out_position,
  input wire logic [15:0] out_line_number,
  input wire logic        out_last
);

  logic [49:0] out_payload;
  logic        out_stall;
  logic        text_beat;

  assign out_payload = {out_kind, out_glyph_id, out_position, out_line_number, out_last};
  assign out_stall   = out_valid && !out_ready;
  assign text_beat   = in_valid && in_ready &&
                       ((in_cmd == gtw_pkg::CMD_TEXT) || (in_cmd == gtw_pkg::CMD_END));

  `GTW_ASSERT(a_out_hold, out_stall |=> out_valid, "result beat dropped while stalled")
  `GTW_ASSERT(a_out_stable, out_stall |=> $stable(out_payload), "stalled result changed")
  `GTW_ASSERT(a_last_is_line, (out_valid && out_last) |-> (out_kind == gtw_pkg::KIND_LINE), "last flag on a glyph record")
  `GTW_ASSERT(a_line_id_zero, (out_valid && (out_kind == gtw_pkg::KIND_LINE)) |-> (out_glyph_id == 7'd0), "line record with glyph id")
  `GTW_ASSERT(a_text_busy, text_beat |=> !in_ready, "text beat did not start processing")

endmodule

bind greedy_text_wrap_layout gtw_checker u_gtw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_glyph_id    (out_ch.glyph_id),
  .out_position    (out_ch.position),
  .out_line_number (out_ch.line_number),
  .out_last        (out_ch.last)
);

`default_nettype wire
